// File: hdl/direct_cross_correlation_defines.svh
// ----------------------------------------------------------------------------
// Direct cross-correlation assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef DIRECT_CROSS_CORRELATION_DEFINES_SVH
`define DIRECT_CROSS_CORRELATION_DEFINES_SVH

// same-cycle implication
`define DCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/dcc_pkg.sv
// ----------------------------------------------------------------------------
// Direct cross-correlation package
// Field widths, codes, states and control structs.
// ----------------------------------------------------------------------------
package dcc_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned ENTRY_BITS  = 2 * SAMPLE_BITS;
  localparam int unsigned PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int unsigned ACC_BITS    = 43;
  localparam int unsigned IDX_BITS    = 10;
  localparam int unsigned LEN_BITS    = 11;
  localparam int unsigned LAG_BITS    = 11;
  localparam int unsigned CFG_BITS    = 11;

  typedef enum logic [1:0] {
    FUNC_WR_A = 2'd0,
    FUNC_WR_B = 2'd1,
    FUNC_LAG  = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_LEN_A = 2'd0,
    CFG_LEN_B = 2'd1,
    CFG_CPLX  = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic clr;
    logic vld;
    logic im;
  } mac_ctl_t;

endpackage

// File: hdl/dcc_if.sv
// ----------------------------------------------------------------------------
// Direct cross-correlation channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dcc_in_if;
  logic                                       valid;
  logic                                       ready;
  logic [1:0]                                 func;
  logic [dcc_pkg::IDX_BITS-1:0]               sample_index;
  logic signed [dcc_pkg::SAMPLE_BITS-1:0]     sample_re;
  logic signed [dcc_pkg::SAMPLE_BITS-1:0]     sample_im;
  logic [dcc_pkg::LAG_BITS-1:0]               lag;

  modport source (output valid, func, sample_index, sample_re, sample_im, lag,
                  input ready);
  modport sink   (input valid, func, sample_index, sample_re, sample_im, lag,
                  output ready);
endinterface

interface dcc_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [dcc_pkg::ACC_BITS-1:0]        corr_value;
  logic [dcc_pkg::LAG_BITS-1:0]               lag_echo;
  logic                                       lag_error;

  modport source (output valid, corr_value, lag_echo, lag_error, input ready);
  modport sink   (input valid, corr_value, lag_echo, lag_error, output ready);
endinterface

// File: hdl/dcc_ram.sv
// ----------------------------------------------------------------------------
// Sample store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dcc_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/dcc_mac.sv
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Registered 16x16 product, then saturating 43-bit accumulate.
// ----------------------------------------------------------------------------
module dcc_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dcc_pkg::mac_ctl_t                     ctl_i,
  input  logic [dcc_pkg::ENTRY_BITS-1:0]        a_i,
  input  logic [dcc_pkg::ENTRY_BITS-1:0]        b_i,
  output logic signed [dcc_pkg::ACC_BITS-1:0]   acc_o,
  output logic                                  busy_o
);

  localparam int unsigned SW = dcc_pkg::SAMPLE_BITS;
  localparam int unsigned AW = dcc_pkg::ACC_BITS;

  logic signed [SW-1:0]                   a_sel, b_sel;
  logic signed [dcc_pkg::PROD_BITS-1:0]   mul_d, mul_q;
  logic                                   mul_v_q;
  logic signed [AW:0]                     sum;
  logic signed [AW-1:0]                   acc_d, acc_q;

  always_comb begin
    a_sel = ctl_i.im ? a_i[2*SW-1:SW] : a_i[SW-1:0];
    b_sel = ctl_i.im ? b_i[2*SW-1:SW] : b_i[SW-1:0];
    mul_d = a_sel * b_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else begin
      mul_v_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
  end

  always_comb begin
    sum   = (AW+1)'(mul_q) + (AW+1)'(acc_q);
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (mul_v_q) begin
      if (sum[AW] != sum[AW-1]) begin
        // saturate toward the sign of the true sum
        acc_d = sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end else begin
        acc_d = sum[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = mul_v_q;

endmodule

// File: hdl/direct_cross_correlation.sv
// ----------------------------------------------------------------------------
// Direct full-lag cross-correlation engine
// A lag request reads its P overlap pairs (P up to 1024) in order, both parts
// of each in complex mode; an out-of-range lag goes straight to the result.
// Throughput: one request at a time, ready again as the word loads; writes 1/cycle
// while idle. Reset clears control and configuration (lengths 1024, real
// mode); the sample stores hold nothing defined until written.
// ----------------------------------------------------------------------------
module direct_cross_correlation #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [dcc_pkg::CFG_BITS-1:0]  cfg_data_i,
  dcc_in_if.sink                        in_i,
  dcc_out_if.source                     out_o
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = dcc_pkg::LEN_BITS;
  localparam int unsigned KW = dcc_pkg::LAG_BITS;
  localparam logic [LW-1:0] MAX_LEN_L = LW'(MAX_LEN);

  // configuration
  logic [LW-1:0] len_a_q, len_b_q;
  logic          cplx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_a_q <= LW'(1024);
      len_b_q <= LW'(1024);
      cplx_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (dcc_pkg::cfg_idx_e'(cfg_idx_i))
        dcc_pkg::CFG_LEN_A: len_a_q <= cfg_data_i[LW-1:0];
        dcc_pkg::CFG_LEN_B: len_b_q <= cfg_data_i[LW-1:0];
        dcc_pkg::CFG_CPLX:  cplx_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer state
  dcc_pkg::state_e state_q, state_d;
  logic [AW-1:0]   n_q, n_d, j_q, j_d;
  logic [LW-1:0]   cnt_q, cnt_d;
  logic            phase_q, phase_d;
  logic [KW-1:0]   lag_q, lag_d;
  logic            err_q, err_d;
  logic            rd_v_q, rd_im_q;
  logic            out_v_q, out_v_d;
  logic signed [dcc_pkg::ACC_BITS-1:0] out_val_q;
  logic [KW-1:0]   out_lag_q;
  logic            out_err_q;
  logic            out_load;

  // request decode
  logic [LW-1:0]   la, lb, lbm1, lam1, nmin, nmax, jst;
  logic [LW:0]     last_lag;
  logic            lag_bad, acc_fire, wr_ok;
  logic            issue_v, issue_im;
  dcc_pkg::mac_ctl_t mac_ctl;
  logic            mac_busy;
  logic signed [dcc_pkg::ACC_BITS-1:0] acc;
  logic [dcc_pkg::ENTRY_BITS-1:0] a_rd, b_rd, wdata;

  always_comb begin
    la = (len_a_q == '0) ? LW'(1) : ((len_a_q > MAX_LEN_L) ? MAX_LEN_L : len_a_q);
    lb = (len_b_q == '0) ? LW'(1) : ((len_b_q > MAX_LEN_L) ? MAX_LEN_L : len_b_q);
    lbm1     = lb - LW'(1);
    lam1     = la - LW'(1);
    last_lag = {1'b0, la} + {1'b0, lb} - (LW+1)'(2);
    lag_bad  = {1'b0, in_i.lag} > last_lag;
    nmin     = (in_i.lag >= lbm1) ? in_i.lag - lbm1 : '0;
    jst      = (in_i.lag >= lbm1) ? '0 : lbm1 - in_i.lag;
    nmax     = (lam1 < in_i.lag) ? lam1 : in_i.lag;
  end

  assign in_i.ready = (state_q == dcc_pkg::ST_IDLE);
  assign acc_fire   = in_i.valid && in_i.ready;
  assign wr_ok      = 32'(in_i.sample_index) < MAX_LEN;
  assign out_load   = (state_q == dcc_pkg::ST_FINISH) && (!out_v_q || out_o.ready);

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    j_d      = j_q;
    cnt_d    = cnt_q;
    phase_d  = phase_q;
    lag_d    = lag_q;
    err_d    = err_q;
    issue_v  = 1'b0;
    issue_im = 1'b0;
    mac_ctl  = '0;
    case (state_q)
      dcc_pkg::ST_IDLE: begin
        if (acc_fire && (dcc_pkg::func_e'(in_i.func) == dcc_pkg::FUNC_LAG)) begin
          mac_ctl.clr = 1'b1;
          lag_d       = in_i.lag;
          err_d       = lag_bad;
          n_d         = AW'(nmin);
          j_d         = AW'(jst);
          cnt_d       = nmax - nmin;
          phase_d     = 1'b0;
          state_d     = lag_bad ? dcc_pkg::ST_FINISH : dcc_pkg::ST_RUN;
        end
      end
      dcc_pkg::ST_RUN: begin
        issue_v  = 1'b1;
        issue_im = phase_q;
        if (cplx_q && !phase_q) begin
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          if (cnt_q == '0) begin
            state_d = dcc_pkg::ST_DRAIN;
          end else begin
            n_d   = n_q + AW'(1);
            j_d   = j_q + AW'(1);
            cnt_d = cnt_q - LW'(1);
          end
        end
      end
      dcc_pkg::ST_DRAIN: begin
        if (!rd_v_q && !mac_busy) begin
          state_d = dcc_pkg::ST_FINISH;
        end
      end
      dcc_pkg::ST_FINISH: begin
        if (out_load) begin
          state_d = dcc_pkg::ST_IDLE;
        end
      end
      default: state_d = dcc_pkg::ST_IDLE;
    endcase
    mac_ctl.vld = rd_v_q;
    mac_ctl.im  = rd_im_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dcc_pkg::ST_IDLE;
      rd_v_q  <= 1'b0;
      rd_im_q <= 1'b0;
      phase_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= issue_v;
      rd_im_q <= issue_im;
      phase_q <= phase_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    j_q   <= j_d;
    cnt_q <= cnt_d;
    lag_q <= lag_d;
    err_q <= err_d;
  end

  // result register
  always_comb begin
    out_v_d = out_v_q;
    if (out_o.ready) begin
      out_v_d = 1'b0;
    end
    if (out_load) begin
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q <= acc;
      out_lag_q <= lag_q;
      out_err_q <= err_q;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.corr_value = out_val_q;
  assign out_o.lag_echo   = out_lag_q;
  assign out_o.lag_error  = out_err_q;

  // stores
  assign wdata = {in_i.sample_im, in_i.sample_re};

  dcc_ram #(
    .DEPTH (MAX_LEN),
    .WIDTH (dcc_pkg::ENTRY_BITS)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (acc_fire && wr_ok &&
              (dcc_pkg::func_e'(in_i.func) == dcc_pkg::FUNC_WR_A)),
    .waddr_i (AW'(in_i.sample_index)),
    .wdata_i (wdata),
    .raddr_i (n_q),
    .rdata_o (a_rd)
  );

  dcc_ram #(
    .DEPTH (MAX_LEN),
    .WIDTH (dcc_pkg::ENTRY_BITS)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (acc_fire && wr_ok &&
              (dcc_pkg::func_e'(in_i.func) == dcc_pkg::FUNC_WR_B)),
    .waddr_i (AW'(in_i.sample_index)),
    .wdata_i (wdata),
    .raddr_i (j_q),
    .rdata_o (b_rd)
  );

  dcc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (a_rd),
    .b_i    (b_rd),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

endmodule

// File: hdl/dcc_checker.sv
// ----------------------------------------------------------------------------
// Direct cross-correlation port checker
// Watches the top-level ports; bound to the top level.
// ----------------------------------------------------------------------------
`include "direct_cross_correlation_defines.svh"

module dcc_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic [1:0]                           in_func_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic signed [dcc_pkg::ACC_BITS-1:0]  corr_value_i,
  input logic [dcc_pkg::LAG_BITS-1:0]         lag_echo_i,
  input logic                                 lag_error_i
);

  `DCC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(corr_value_i) && $stable(lag_echo_i), "result word changed while stalled")
  `DCC_ASSERT_NOW(a_err_zero, out_valid_i && lag_error_i, corr_value_i == '0, "error word carries a nonzero value")
  `DCC_ASSERT_NOW(a_top_lag_err, out_valid_i && (lag_echo_i == '1), lag_error_i, "largest lag not flagged")
  `DCC_ASSERT_NEXT(a_busy_after_lag, in_valid_i && in_ready_i && (in_func_i == dcc_pkg::FUNC_LAG), !in_ready_i, "ready right after a lag request")

endmodule

bind direct_cross_correlation dcc_checker u_dcc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_func_i    (in_i.func),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .corr_value_i (out_o.corr_value),
  .lag_echo_i   (out_o.lag_echo),
  .lag_error_i  (out_o.lag_error)
);

// File: tb/direct_cross_correlation_test.sv
// ----------------------------------------------------------------------------
// Direct cross-correlation engine test
// Writes sample words into both stores and requests lags under several
// length and mode settings. Every lag result is compared with an in-bench
// correlation predictor or a typed expectation. A short directed table comes
// first, then random phases. Reads of never-written store entries never occur.
// ----------------------------------------------------------------------------
module direct_cross_correlation_test;
  import dcc_pkg::*;

  localparam int MAX_LEN       = 1024;
  localparam int LAG_TOP       = (1 << LAG_BITS) - 1;
  localparam int ITEM_TARGET   = 580;
  localparam int SETTLE_CYCLES = 8;
  localparam longint ACC_MAX   = (longint'(1) << (ACC_BITS - 1)) - 1;
  localparam longint ACC_MIN   = -ACC_MAX - 1;

  typedef struct packed {
    func_e                         func;
    logic [IDX_BITS-1:0]           idx;
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic [LAG_BITS-1:0]           lag;
  } word_t;

  typedef struct packed {
    logic signed [ACC_BITS-1:0] corr;
    logic [LAG_BITS-1:0]        lag;
    logic                       err;
  } corr_t;

  typedef struct packed {
    logic                is_cfg;
    cfg_idx_e            reg_sel;
    logic [CFG_BITS-1:0] reg_val;
    word_t               word;
    logic                typed;
    corr_t               want;
  } row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CFG_BITS-1:0] cfg_data;

  dcc_in_if  in_ch ();
  dcc_out_if out_ch ();

  direct_cross_correlation dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // predictor state
  logic signed [SAMPLE_BITS-1:0] a_re [MAX_LEN];
  logic signed [SAMPLE_BITS-1:0] a_im [MAX_LEN];
  logic signed [SAMPLE_BITS-1:0] b_re [MAX_LEN];
  logic signed [SAMPLE_BITS-1:0] b_im [MAX_LEN];
  bit                            a_written [MAX_LEN];
  bit                            b_written [MAX_LEN];
  logic [CFG_BITS-1:0]           len_a_reg = 11'd1024;
  logic [CFG_BITS-1:0]           len_b_reg = 11'd1024;
  logic                          cplx_reg  = 1'b0;

  corr_t pending_corr_q [$];

  bit calm;
  bit sink_calm;
  int error_count;
  int items_sent;
  int n_writes;
  int n_requests;
  int n_lag_errors;
  int n_checked;
  int n_settings;
  int n_complex;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint used_length(logic [CFG_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_LEN) return MAX_LEN;
    return longint'(v);
  endfunction

  function automatic longint clamp_acc(longint s);
    if (s > ACC_MAX) return ACC_MAX;
    if (s < ACC_MIN) return ACC_MIN;
    return s;
  endfunction

  function automatic corr_t correlate_at_lag(logic [LAG_BITS-1:0] k);
    corr_t  r;
    longint la, lb, kk, n, j, acc;
    la     = used_length(len_a_reg);
    lb     = used_length(len_b_reg);
    kk     = longint'(k);
    r.lag  = k;
    r.err  = 1'b0;
    r.corr = '0;
    if (kk > la + lb - 2) begin
      r.err = 1'b1;
      return r;
    end
    acc = 0;
    for (n = 0; n < la; n++) begin
      j = n + lb - 1 - kk;
      if (j < 0 || j >= lb) continue;
      acc = clamp_acc(acc + longint'(a_re[n]) * longint'(b_re[j]));
      if (cplx_reg) acc = clamp_acc(acc + longint'(a_im[n]) * longint'(b_im[j]));
    end
    r.corr = acc[ACC_BITS-1:0];
    return r;
  endfunction

  // true when every entry in the overlap of lag k has been written
  function automatic bit lag_is_readable(int k);
    longint la, lb, n, j;
    la = used_length(len_a_reg);
    lb = used_length(len_b_reg);
    for (n = 0; n < la; n++) begin
      j = n + lb - 1 - k;
      if (j < 0 || j >= lb) continue;
      if (!a_written[n] || !b_written[j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] draw_length();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 11'd0;
          1:       return 11'd1;
          2:       return 11'd1024;
          default: return 11'd2047;
        endcase
      end
      1:       return CFG_BITS'($urandom_range(17, 40));
      default: return CFG_BITS'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic int pick_lag(int top);
    int k, t, edge_span;
    edge_span = (top < 7) ? top : 7;
    for (t = 0; t < 16; t++) begin
      case ($urandom_range(0, 2))
        0:       k = $urandom_range(0, top);
        1:       k = $urandom_range(0, edge_span);
        default: k = top - $urandom_range(0, edge_span);
      endcase
      if (lag_is_readable(k)) return k;
    end
    return LAG_TOP;
  endfunction

  function automatic word_t rand_word(func_e f, int idx);
    word_t w;
    w.func = f;
    w.idx  = IDX_BITS'(idx);
    w.re   = draw_sample();
    w.im   = draw_sample();
    w.lag  = LAG_BITS'($urandom);
    return w;
  endfunction

  function automatic row_t mk_write(func_e f, int idx, int re, int im);
    row_t r;
    r         = '0;
    r.word    = rand_word(f, idx);
    r.word.re = SAMPLE_BITS'(re);
    r.word.im = SAMPLE_BITS'(im);
    return r;
  endfunction

  function automatic row_t mk_lag(int k);
    row_t r;
    r          = '0;
    r.word     = rand_word(FUNC_LAG, $urandom_range(0, MAX_LEN - 1));
    r.word.lag = LAG_BITS'(k);
    return r;
  endfunction

  function automatic row_t mk_lag_typed(int k, longint corr, bit err);
    row_t r;
    r           = mk_lag(k);
    r.typed     = 1'b1;
    r.want.corr = ACC_BITS'(corr);
    r.want.lag  = LAG_BITS'(k);
    r.want.err  = err;
    return r;
  endfunction

  function automatic row_t mk_cfg(cfg_idx_e sel, int v);
    row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_sel = sel;
    r.reg_val = CFG_BITS'(v);
    return r;
  endfunction

  task automatic send_word(input word_t w, input bit typed, input corr_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= w.func;
    in_ch.sample_index <= w.idx;
    in_ch.sample_re    <= w.re;
    in_ch.sample_im    <= w.im;
    in_ch.lag          <= w.lag;
    do @(posedge clk); while (!in_ch.ready);
    case (w.func)
      FUNC_WR_A: begin
        a_re[w.idx]      = w.re;
        a_im[w.idx]      = w.im;
        a_written[w.idx] = 1'b1;
        n_writes++;
        items_sent++;
      end
      FUNC_WR_B: begin
        b_re[w.idx]      = w.re;
        b_im[w.idx]      = w.im;
        b_written[w.idx] = 1'b1;
        n_writes++;
        items_sent++;
      end
      FUNC_LAG: begin
        pending_corr_q.push_back(typed ? want : correlate_at_lag(w.lag));
        n_requests++;
        items_sent++;
      end
      default: ;
    endcase
  endtask

  // drop valid, let all results drain and the pipeline go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_corr_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_e sel, input logic [CFG_BITS-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= sel;
    cfg_data <= val;
    @(posedge clk);
    case (sel)
      CFG_LEN_A: len_a_reg = val;
      CFG_LEN_B: len_b_reg = val;
      CFG_CPLX:  cplx_reg  = val[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic fill_store(input func_e f, input int len_e);
    int i, n_fill;
    bit down;
    n_fill = (len_e <= 64) ? len_e : 8;
    down   = 1'($urandom_range(0, 1));
    for (i = 0; i < n_fill; i++) begin
      if (len_e <= 64) begin
        send_word(rand_word(f, down ? len_e - 1 - i : i), 1'b0, '0);
      end else begin
        send_word(rand_word(f, (i < 4) ? i : len_e - 8 + i), 1'b0, '0);
      end
    end
  endtask

  // result side: random stalls, check each word against the oldest expectation
  initial begin
    corr_t want;
    int    stall;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_corr_q.size() == 0) begin
        $error("unexpected result word, lag_echo %0d", out_ch.lag_echo);
        error_count++;
      end else begin
        want = pending_corr_q.pop_front();
        n_checked++;
        if (out_ch.corr_value !== want.corr) begin
          $error("corr_value: expected %0d, got %0d", want.corr, out_ch.corr_value);
          error_count++;
        end
        if (out_ch.lag_echo !== want.lag) begin
          $error("lag_echo: expected %0d, got %0d", want.lag, out_ch.lag_echo);
          error_count++;
        end
        if (out_ch.lag_error !== want.err) begin
          $error("lag_error: expected %0d, got %0d", want.err, out_ch.lag_error);
          error_count++;
        end
        if (want.err) n_lag_errors++;
      end
      if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
    end
  end

  initial begin
    #100_000_000;
    $display("direct_cross_correlation_test: errors");
    $finish;
  end

  initial begin
    row_t                directed_rows [];
    logic [CFG_BITS-1:0] la_raw, lb_raw;
    int                  la_e, lb_e, top, i, n_req;
    bit                  cx, b_first;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_LEN_A;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_NOP;
    in_ch.sample_index <= '0;
    in_ch.sample_re    <= '0;
    in_ch.sample_im    <= '0;
    in_ch.lag          <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_rows = '{
      mk_write(FUNC_WR_A, 0, -32768, 32767),
      mk_write(FUNC_WR_B, 1023, -32768, -32768),
      mk_lag_typed(0, 1073741824, 1'b0),
      mk_write(FUNC_WR_A, 1023, 32767, -1),
      mk_write(FUNC_WR_B, 0, -32768, 0),
      mk_lag_typed(2046, -1073709056, 1'b0),
      mk_lag_typed(2047, 0, 1'b1),
      mk_write(FUNC_NOP, 1023, -1, -1),
      mk_cfg(CFG_CPLX, 1),
      mk_lag(0),
      mk_lag(2046),
      mk_cfg(CFG_NONE, 2047),
      mk_lag(0),
      mk_cfg(CFG_LEN_A, 0),
      mk_cfg(CFG_LEN_B, 2047),
      mk_lag(1023),
      mk_lag_typed(1024, 0, 1'b1),
      mk_cfg(CFG_LEN_B, 1),
      mk_lag(0),
      mk_lag_typed(1, 0, 1'b1),
      mk_cfg(CFG_CPLX, 0),
      mk_lag_typed(0, 1073741824, 1'b0),
      mk_lag_typed(2047, 0, 1'b1)
    };

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        settle();
        write_register(directed_rows[r].reg_sel, directed_rows[r].reg_val);
      end else begin
        send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    while (items_sent < ITEM_TARGET) begin
      settle();
      calm   = ($urandom_range(0, 3) == 0);
      la_raw = draw_length();
      lb_raw = draw_length();
      cx     = 1'($urandom_range(0, 1));
      write_register(CFG_LEN_A, la_raw);
      write_register(CFG_LEN_B, lb_raw);
      write_register(CFG_CPLX, CFG_BITS'(($urandom & 32'h7fe) | 32'(cx)));
      if ($urandom_range(0, 4) == 0) write_register(CFG_NONE, CFG_BITS'($urandom));
      n_settings++;
      if (cx) n_complex++;
      la_e = int'(used_length(la_raw));
      lb_e = int'(used_length(lb_raw));
      top  = la_e + lb_e - 2;

      b_first = 1'($urandom_range(0, 1));
      fill_store(b_first ? FUNC_WR_B : FUNC_WR_A, b_first ? lb_e : la_e);
      fill_store(b_first ? FUNC_WR_A : FUNC_WR_B, b_first ? la_e : lb_e);

      n_req = $urandom_range(6, 16);
      for (i = 0; i < n_req; i++) begin
        case ($urandom_range(0, 19))
          0:    send_word(rand_word(FUNC_NOP, $urandom_range(0, MAX_LEN - 1)), 1'b0, '0);
          1:    send_word(rand_word(FUNC_WR_A, $urandom_range(0, MAX_LEN - 1)), 1'b0, '0);
          2:    send_word(rand_word(FUNC_WR_B, $urandom_range(0, MAX_LEN - 1)), 1'b0, '0);
          3, 4: send_word(mk_lag($urandom_range(top + 1, LAG_TOP)).word, 1'b0, '0);
          default: send_word(mk_lag(pick_lag(top)).word, 1'b0, '0);
        endcase
      end
    end

    settle();
    $display("Ran %0d sample writes and %0d lag requests over %0d register settings,",
             n_writes, n_requests, n_settings);
    $display("%0d settings in complex mode; %0d results checked, %0d of them lag errors.",
             n_complex, n_checked, n_lag_errors);
    if (error_count == 0) begin
      $display("direct_cross_correlation_test: clean");
    end else begin
      $display("direct_cross_correlation_test: errors");
    end
    $finish;
  end

endmodule

// File: direct_cross_correlation.f
+incdir+hdl
hdl/dcc_pkg.sv
hdl/dcc_if.sv
hdl/dcc_ram.sv
hdl/dcc_mac.sv
hdl/direct_cross_correlation.sv
hdl/dcc_checker.sv
tb/direct_cross_correlation_test.sv
